// ----- src/dpec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpec_pkg
// Types, constants and step functions for the disc pair collision pipeline.
// ----------------------------------------------------------------------------
package dpec_pkg;

  localparam int unsigned NSHIFT     = 30;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned DIV_LANES  = 4;
  localparam logic [16:0] E_ONE      = 17'h10000;

  // lane roles inside the divider bank
  localparam int unsigned LANE_NX = 0;
  localparam int unsigned LANE_NY = 1;
  localparam int unsigned LANE_WA = 2;
  localparam int unsigned LANE_WB = 3;

  typedef enum logic [1:0] {
    ST_MISS = 2'd0,
    ST_SEP  = 2'd1,
    ST_HIT  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic [30:0]        a_radius;
    logic [30:0]        a_mass;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [30:0]        b_radius;
    logic [30:0]        b_mass;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
  } out_beat_t;

  // side data that rides along with each pair
  typedef struct packed {
    logic               hit;
    logic               sx;
    logic               sy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic [30:0]        mxn;
    logic [30:0]        myn;
  } carry_t;

  typedef struct packed {
    logic [63:0] q;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [33:0] r;
    logic [32:0] d;
    logic [30:0] q;
  } div_lane_t;

  // one digit of the integer square root
  function automatic sqrt_t sqrt_step(sqrt_t x, int unsigned j);
    logic [63:0] b;
    logic [63:0] t;
    sqrt_t       y;
    b = 64'd1 << (62 - 2 * j);
    t = x.res + b;
    y = x;
    if (x.q >= t) begin
      y.q   = x.q - t;
      y.res = (x.res >> 1) + b;
    end else begin
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  // one quotient bit of a restoring divide
  function automatic div_lane_t div_step(div_lane_t x);
    div_lane_t y;
    y = x;
    if (x.r >= {1'b0, x.d}) begin
      y.r = x.r - {1'b0, x.d};
      y.q = {x.q[29:0], 1'b1};
    end else begin
      y.q = {x.q[29:0], 1'b0};
    end
    y.r = {y.r[32:0], 1'b0};
    return y;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [36:0] x);
    if (x > 37'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- src/disc_pair_elastic_collision_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_pair_elastic_collision_top
// Two-disc overlap check and impulse response along the contact normal.
// ----------------------------------------------------------------------------
// usage
//   in channel: one beat per disc pair (positions, velocities, radii, masses,
//   all Q16.16), taken at a clock edge with in_valid high and in_stall low
//   out channel: one beat per pair, status plus both new velocities, given in
//   the same order as the pairs arrived
//   cfg port: cfg_we writes cfg_wdata into the restitution register, values
//   above 1.0 clip to 1.0; write only while the pipeline is empty
// timing
//   one pair per cycle sustained while no held output beat stalls the pipe;
//   the 32-step root and 31-step divide bank set the depth
// reset
//   rst clears every stage valid bit and sets restitution to 1.0
// stall
//   the whole pipeline freezes while a finished beat sits at the output and
//   out_stall is high; in_stall follows so nothing is dropped or repeated
// ----------------------------------------------------------------------------
module disc_pair_elastic_collision_top
  import dpec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  logic        adv;
  logic [16:0] restitution;

  // pipe advances unless the output holds an untaken beat
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= E_ONE;
    end else if (cfg_we) begin
      restitution <= (cfg_wdata > E_ONE) ? E_ONE : cfg_wdata;
    end
  end

  // front end: differences, squares, overlap, normalize
  logic               v1, v2, v3, v4;
  carry_t             c1, c2, c3, c4;
  carry_t             c3_next;
  logic signed [32:0] dx1, dy1;
  logic [31:0]        rs1;
  logic [63:0]        dx2, dy2, rs2;
  logic [31:0]        mx2, my2;
  logic [61:0]        xx4, yy4;

  logic signed [32:0] dx_c, dy_c;
  logic [31:0]        mx_c, my_c, m_c;
  logic [4:0]         k_c;
  logic [30:0]        mxn_c, myn_c;

  assign dx_c = 33'(in_data.a_pos_x) - 33'(in_data.b_pos_x);
  assign dy_c = 33'(in_data.a_pos_y) - 33'(in_data.b_pos_y);

  assign mx_c = dx1[32] ? 32'(-dx1) : dx1[31:0];
  assign my_c = dy1[32] ? 32'(-dy1) : dy1[31:0];
  assign m_c  = (mx2 > my2) ? mx2 : my2;

  // leading zero count so the larger magnitude lands on bit 30
  always_comb begin
    k_c = '0;
    for (int i = 0; i <= 30; i++) begin
      if (m_c[i]) k_c = 5'(30 - i);
    end
    if (m_c[31]) begin
      mxn_c = mx2[31:1];
      myn_c = my2[31:1];
    end else begin
      mxn_c = mx2[30:0] << k_c;
      myn_c = my2[30:0] << k_c;
    end
  end

  // overlap flag and normalized magnitudes join the side data
  always_comb begin
    c3_next     = c2;
    c3_next.hit = (({2'b0, dx2} + {2'b0, dy2}) < {2'b0, rs2}) && ((mx2 | my2) != '0);
    c3_next.mxn = mxn_c;
    c3_next.myn = myn_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1      <= dx_c;
      dy1      <= dy_c;
      rs1      <= 32'(in_data.a_radius) + 32'(in_data.b_radius);
      c1.hit   <= 1'b0;
      c1.sx    <= dx_c[32];
      c1.sy    <= dy_c[32];
      c1.rvx   <= 33'(in_data.a_vel_x) - 33'(in_data.b_vel_x);
      c1.rvy   <= 33'(in_data.a_vel_y) - 33'(in_data.b_vel_y);
      c1.avx   <= in_data.a_vel_x;
      c1.avy   <= in_data.a_vel_y;
      c1.bvx   <= in_data.b_vel_x;
      c1.bvy   <= in_data.b_vel_y;
      c1.ma    <= (in_data.a_mass == '0) ? 31'd1 : in_data.a_mass;
      c1.mb    <= (in_data.b_mass == '0) ? 31'd1 : in_data.b_mass;
      c1.mxn   <= '0;
      c1.myn   <= '0;

      mx2 <= mx_c;
      my2 <= my_c;
      dx2 <= mx_c * mx_c;
      dy2 <= my_c * my_c;
      rs2 <= rs1 * rs1;
      c2  <= c1;

      c3 <= c3_next;

      xx4 <= c3.mxn * c3.mxn;
      yy4 <= c3.myn * c3.myn;
      c4  <= c3;
    end
  end

  // square root pipeline, one result bit per stage
  logic   sq_v [0:SQRT_STEPS];
  carry_t sq_c [0:SQRT_STEPS];
  sqrt_t  sq_s [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c[0]     <= c4;
      sq_s[0].q   <= 64'(xx4) + 64'(yy4);
      sq_s[0].res <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (adv) begin
        sq_v[j+1] <= sq_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[j+1] <= sq_c[j];
        sq_s[j+1] <= sqrt_step(sq_s[j], j);
      end
    end
  end

  // divider bank: normal x, normal y and both mass weights
  logic      dv_v [0:DIV_STEPS];
  carry_t    dv_c [0:DIV_STEPS];
  div_lane_t dv_l [0:DIV_STEPS][DIV_LANES];
  logic [32:0] len_c, msum_c;

  assign len_c  = {1'b0, sq_s[SQRT_STEPS].res[31:0]};
  assign msum_c = 33'(sq_c[SQRT_STEPS].ma) + 33'(sq_c[SQRT_STEPS].mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c[0]          <= sq_c[SQRT_STEPS];
      dv_l[0][LANE_NX] <= '{r: 34'(sq_c[SQRT_STEPS].mxn), d: len_c, q: '0};
      dv_l[0][LANE_NY] <= '{r: 34'(sq_c[SQRT_STEPS].myn), d: len_c, q: '0};
      dv_l[0][LANE_WA] <= '{r: 34'(sq_c[SQRT_STEPS].mb), d: msum_c, q: '0};
      dv_l[0][LANE_WB] <= '{r: 34'(sq_c[SQRT_STEPS].ma), d: msum_c, q: '0};
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1] <= dv_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[j+1] <= dv_c[j];
        for (int l = 0; l < DIV_LANES; l++) begin
          dv_l[j+1][l] <= div_step(dv_l[j][l]);
        end
      end
    end
  end

  // back end: normal velocity, impulse, per-axis deltas, saturate
  logic               p1v, p2v, p3v, p4v, p5v;
  carry_t             p1c, p2c, p3c, p4c, p5c;
  logic [30:0]        p1nx, p1ny, p2nx, p2ny, p3nx, p3ny, p4nx, p4ny;
  logic [30:0]        p1wa, p1wb, p2wa, p2wb, p3wa, p3wb;
  logic signed [64:0] p1rx, p1ry;
  logic signed [65:0] p2s;
  status_t            p2st, p3st, p4st, p5st;
  logic [51:0]        p3vm;
  logic [66:0]        p4ka, p4kb;
  logic [65:0]        p5ax, p5ay, p5bx, p5by;

  logic signed [31:0] nxs_c, nys_c;
  logic signed [65:0] s_c, pneg_c;
  logic [35:0]        u_c;
  logic [34:0]        ka_c, kb_c;
  logic [35:0]        dax_c, day_c, dbx_c, dby_c;
  logic signed [36:0] dsax_c, dsay_c, dsbx_c, dsby_c;
  logic               hit5_c;

  assign nxs_c  = dv_c[DIV_STEPS].sx ? -$signed({1'b0, dv_l[DIV_STEPS][LANE_NX].q})
                                     :  $signed({1'b0, dv_l[DIV_STEPS][LANE_NX].q});
  assign nys_c  = dv_c[DIV_STEPS].sy ? -$signed({1'b0, dv_l[DIV_STEPS][LANE_NY].q})
                                     :  $signed({1'b0, dv_l[DIV_STEPS][LANE_NY].q});
  assign s_c    = 66'(p1rx) + 66'(p1ry);
  assign pneg_c = -p2s;
  assign u_c    = p3vm[51:16];
  assign ka_c   = p4ka[64:30];
  assign kb_c   = p4kb[64:30];
  assign dax_c  = p5ax[65:30];
  assign day_c  = p5ay[65:30];
  assign dbx_c  = p5bx[65:30];
  assign dby_c  = p5by[65:30];
  assign hit5_c = (p5st == ST_HIT);

  // deltas only apply when the impulse is taken
  assign dsax_c = !hit5_c ? '0 : (p5c.sx ? -$signed({1'b0, dax_c}) : $signed({1'b0, dax_c}));
  assign dsay_c = !hit5_c ? '0 : (p5c.sy ? -$signed({1'b0, day_c}) : $signed({1'b0, day_c}));
  assign dsbx_c = !hit5_c ? '0 : (p5c.sx ? -$signed({1'b0, dbx_c}) : $signed({1'b0, dbx_c}));
  assign dsby_c = !hit5_c ? '0 : (p5c.sy ? -$signed({1'b0, dby_c}) : $signed({1'b0, dby_c}));

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v       <= 1'b0;
      p2v       <= 1'b0;
      p3v       <= 1'b0;
      p4v       <= 1'b0;
      p5v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1v       <= dv_v[DIV_STEPS];
      p2v       <= p1v;
      p3v       <= p2v;
      p4v       <= p3v;
      p5v       <= p4v;
      out_valid <= p5v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1c  <= dv_c[DIV_STEPS];
      p1nx <= dv_l[DIV_STEPS][LANE_NX].q;
      p1ny <= dv_l[DIV_STEPS][LANE_NY].q;
      p1wa <= dv_l[DIV_STEPS][LANE_WA].q;
      p1wb <= dv_l[DIV_STEPS][LANE_WB].q;
      p1rx <= 65'(dv_c[DIV_STEPS].rvx) * 65'(nxs_c);
      p1ry <= 65'(dv_c[DIV_STEPS].rvy) * 65'(nys_c);

      p2c  <= p1c;
      p2nx <= p1nx;
      p2ny <= p1ny;
      p2wa <= p1wa;
      p2wb <= p1wb;
      p2s  <= s_c;
      if (!p1c.hit) begin
        p2st <= ST_MISS;
      end else if (s_c > 66'sd0) begin
        p2st <= ST_SEP;
      end else begin
        p2st <= ST_HIT;
      end

      p3c  <= p2c;
      p3nx <= p2nx;
      p3ny <= p2ny;
      p3wa <= p2wa;
      p3wb <= p2wb;
      p3st <= p2st;
      p3vm <= pneg_c[63:30] * (18'(E_ONE) + 18'(restitution));

      p4c  <= p3c;
      p4nx <= p3nx;
      p4ny <= p3ny;
      p4st <= p3st;
      p4ka <= u_c * p3wa;
      p4kb <= u_c * p3wb;

      p5c  <= p4c;
      p5st <= p4st;
      p5ax <= ka_c * p4nx;
      p5ay <= ka_c * p4ny;
      p5bx <= kb_c * p4nx;
      p5by <= kb_c * p4ny;

      out_data.status      <= p5st;
      out_data.new_a_vel_x <= sat32(37'(p5c.avx) + dsax_c);
      out_data.new_a_vel_y <= sat32(37'(p5c.avy) + dsay_c);
      out_data.new_b_vel_x <= sat32(37'(p5c.bvx) - dsbx_c);
      out_data.new_b_vel_y <= sat32(37'(p5c.bvy) - dsby_c);
    end
  end

  // checks
  a_rest_range: assert property (@(posedge clk) disable iff (rst)
    restitution <= E_ONE)
    else $error("restitution above one");

  a_len_norm: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQRT_STEPS] && sq_c[SQRT_STEPS].hit |-> sq_s[SQRT_STEPS].res[31:30] != 2'b00)
    else $error("normalized length below 2^30");

  a_unit_normal: assert property (@(posedge clk) disable iff (rst)
    dv_v[DIV_STEPS] && dv_c[DIV_STEPS].hit |->
      dv_l[DIV_STEPS][LANE_NX].q <= 31'h40000000 &&
      dv_l[DIV_STEPS][LANE_NY].q <= 31'h40000000)
    else $error("normal component above one");

  a_miss_status: assert property (@(posedge clk) disable iff (rst)
    adv && p1v && !p1c.hit |=> p2st == ST_MISS)
    else $error("miss pair got a response status");

endmodule
